@@ design/bol_pkg.sv @@
// Shared types and codes for the bounded ordered list.
package bol_pkg;

    // Width of one stored value
    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    // Operation codes
    typedef logic [1:0] op_t;
    localparam op_t OP_APPEND = 2'd0;
    localparam op_t OP_SEARCH = 2'd1;
    localparam op_t OP_DELETE = 2'd2;

    // Result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_RANGE     = 2'd2;
    localparam status_t ST_FULL      = 2'd3;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } state_t;

endpackage

@@ design/bol_store.sv @@
// Entry memory: one write port and one registered read port.
module bol_store #(
    parameter int DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  bol_pkg::data_t            wdata,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output bol_pkg::data_t            rdata
);
    import bol_pkg::*;

    data_t mem [DEPTH];
    data_t rdata_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/bounded_ordered_list.sv @@
// Top level of the bounded ordered list: sequencer, walk counter and output register.
//
// Usage:
//   The request channel (req_valid / req_stall) carries op, item_value and
//   target_position. An item is taken at a clock edge with req_valid high and
//   req_stall low. The response channel (rsp_valid / rsp_stall) returns one
//   item per request: found_position, status and length_after.
//   Each result is loaded into the output register as the sequencer returns
//   to idle. Append writes at the tail. Search reads one stored entry per
//   cycle through the single memory read port and one comparator. Delete
//   moves entries down one slot per cycle through the same port. Out-of-range
//   deletes and unused op codes go straight to the result. Only one item is
//   in the block at a time, so req_stall is high from acceptance until the
//   result is loaded into the output register. If the receiver stalls, the
//   result holds in the output register and the sequencer waits in its final
//   state before taking more. Reset empties the list and clears both valid
//   flags; entry contents are not cleared and are never read before written.
module bounded_ordered_list #(
    parameter int CAPACITY = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  bol_pkg::op_t                        op,
    input  bol_pkg::data_t                      item_value,
    input  logic [$clog2(CAPACITY+1)-1:0]       target_position,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [$clog2(CAPACITY+1)-1:0]       found_position,
    output bol_pkg::status_t                    status,
    output logic [$clog2(CAPACITY+1)-1:0]       length_after
);
    import bol_pkg::*;

    localparam int POS_W = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);
    localparam logic [POS_W-1:0] ONE_POS = POS_W'(1);

    state_t              state_reg, state_next;
    logic [POS_W-1:0]    count_reg, count_next;
    logic [POS_W-1:0]    idx_reg, idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [POS_W-1:0]    pend_idx_reg, pend_idx_next;
    data_t               key_reg, key_next;
    logic [POS_W-1:0]    res_found_reg, res_found_next;
    status_t             res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [POS_W-1:0]    out_found_reg, out_found_next;
    status_t             out_status_reg, out_status_next;
    logic [POS_W-1:0]    out_len_reg, out_len_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    data_t               mem_wdata;
    logic [AW-1:0]       mem_raddr;
    data_t               mem_rdata;
    logic [POS_W-1:0]    pend_prev;

    assign pend_prev = pend_idx_reg - ONE_POS;

    bol_store #(
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold walk and result payload
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        pend_idx_reg   <= pend_idx_next;
        key_reg        <= key_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        out_found_reg  <= out_found_next;
        out_status_reg <= out_status_next;
        out_len_reg    <= out_len_next;
    end

    // Sequence each operation
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        key_next        = key_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        out_len_next    = out_len_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[AW-1:0];
        mem_wdata       = item_value;
        mem_raddr       = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_found_next = '0;
                    case (op)
                        OP_APPEND:
                        begin
                            if (count_reg == CAP_POS)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                count_next      = count_reg + ONE_POS;
                                res_status_next = ST_OK;
                            end
                            state_next = S_DONE;
                        end
                        OP_SEARCH:
                        begin
                            key_next        = item_value;
                            idx_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_SEARCH;
                        end
                        OP_DELETE:
                        begin
                            if (target_position == '0 || target_position > count_reg)
                            begin
                                res_status_next = ST_RANGE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                idx_next        = target_position;
                                pend_valid_next = 1'b0;
                                state_next      = S_SHIFT;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                // compare last read entry, issue the next read
                if (pend_valid_reg && mem_rdata == key_reg)
                begin
                    res_found_next  = pend_idx_reg + ONE_POS;
                    res_status_next = ST_OK;
                    pend_valid_next = 1'b0;
                    state_next      = S_DONE;
                end
                else if (idx_reg == count_reg)
                begin
                    res_found_next  = '0;
                    res_status_next = ST_NOT_FOUND;
                    pend_valid_next = 1'b0;
                    state_next      = S_DONE;
                end
                else
                begin
                    pend_valid_next = 1'b1;
                    pend_idx_next   = idx_reg;
                    idx_next        = idx_reg + ONE_POS;
                end
            end

            S_SHIFT:
            begin
                // move last read entry down one slot
                if (pend_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_prev[AW-1:0];
                    mem_wdata = mem_rdata;
                end
                if (idx_reg == count_reg)
                begin
                    count_next      = count_reg - ONE_POS;
                    res_found_next  = '0;
                    res_status_next = ST_OK;
                    pend_valid_next = 1'b0;
                    state_next      = S_DONE;
                end
                else
                begin
                    pend_valid_next = 1'b1;
                    pend_idx_next   = idx_reg;
                    idx_next        = idx_reg + ONE_POS;
                end
            end

            S_DONE:
            begin
                // load the output register once it is free
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = res_found_reg;
                    out_status_next = res_status_reg;
                    out_len_next    = count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_stall      = (state_reg != S_IDLE);
    assign rsp_valid      = out_valid_reg;
    assign found_position = out_found_reg;
    assign status         = out_status_reg;
    assign length_after   = out_len_reg;

endmodule

@@ tb/list_shadow_pkg.sv @@
// Shadow copy of the ordered list and the queue of replies it predicts.
package list_shadow_pkg;

    import bol_pkg::*;

    localparam int LIST_CAPACITY = 16;
    localparam int POS_W = $clog2(LIST_CAPACITY + 1);

    // Op code that the block ignores
    localparam op_t OP_UNUSED = 2'd3;

    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        pos_t    found;
        status_t status;
        pos_t    length;
    } list_reply_t;

    class list_shadow;

        data_t       shadow_entries[LIST_CAPACITY];
        int          shadow_count;
        list_reply_t awaited[$];
        int          failures;

        function new();
            shadow_count = 0;
            failures = 0;
            for (int i = 0; i < LIST_CAPACITY; i++)
            begin
                shadow_entries[i] = '0;
            end
        endfunction

        // Apply one operation to the shadow list and return the reply it gives
        function list_reply_t apply_op(op_t code, data_t value, pos_t pos);
            list_reply_t r;
            bit hit;
            r.found = '0;
            r.status = ST_OK;
            hit = 1'b0;
            case (code)
                OP_APPEND:
                begin
                    if (shadow_count >= LIST_CAPACITY)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        shadow_entries[shadow_count] = value;
                        shadow_count++;
                    end
                end
                OP_SEARCH:
                begin
                    // report the first match only
                    r.status = ST_NOT_FOUND;
                    for (int i = 0; i < shadow_count; i++)
                    begin
                        if (!hit && shadow_entries[i] == value)
                        begin
                            hit = 1'b1;
                            r.found = pos_t'(i + 1);
                            r.status = ST_OK;
                        end
                    end
                end
                OP_DELETE:
                begin
                    if (int'(pos) == 0 || int'(pos) > shadow_count)
                    begin
                        r.status = ST_RANGE;
                    end
                    else
                    begin
                        // close up the order behind the removed entry
                        for (int i = int'(pos) - 1; i < shadow_count - 1; i++)
                        begin
                            shadow_entries[i] = shadow_entries[i + 1];
                        end
                        shadow_count--;
                    end
                end
                default:
                begin
                end
            endcase
            r.length = pos_t'(shadow_count);
            return r;
        endfunction

        // Predict the reply for an accepted request item and queue it
        function void note_request(op_t code, data_t value, pos_t pos);
            awaited.push_back(apply_op(code, value, pos));
        endfunction

        // Compare an accepted reply item against the oldest prediction
        function void check_response(pos_t found, status_t status, pos_t length);
            list_reply_t want;
            if (awaited.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected reply: found %0d status %0d length %0d",
                             found, status, length);
                return;
            end
            want = awaited.pop_front();
            if (want.found !== found || want.status !== status || want.length !== length)
            begin
                failures++;
                if (failures <= 10)
                    $display("reply mismatch: found %0d/%0d status %0d/%0d length %0d/%0d",
                             want.found, found, want.status, status, want.length, length);
            end
        endfunction

        // Pick a value currently held, for searches that should hit
        function data_t stored_value();
            if (shadow_count == 0)
                return data_t'($urandom);
            return shadow_entries[$urandom_range(0, shadow_count - 1)];
        endfunction

    endclass

endpackage

@@ tb/testbench.sv @@
// Top-level testbench for the bounded ordered list.
module testbench;

    import bol_pkg::*;
    import list_shadow_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 400;
    localparam int TAIL_CYCLES = 40;

    logic    clk;
    logic    rst_n;
    logic    req_valid;
    logic    req_stall;
    op_t     op;
    data_t   item_value;
    pos_t    target_position;
    logic    rsp_valid;
    logic    rsp_stall;
    pos_t    found_position;
    status_t status;
    pos_t    length_after;

    int         cycle_count;
    int         idle_pct;
    int         stall_pct;
    list_shadow sb;

    bounded_ordered_list #(
        .CAPACITY(LIST_CAPACITY)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .op(op),
        .item_value(item_value),
        .target_position(target_position),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .found_position(found_position),
        .status(status),
        .length_after(length_after)
    );

    // Free-running clock, period 8
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Stall the reply channel at random
    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Record accepted items on both channels
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(found_position, status, length_after);
        if (rst_n && req_valid && !req_stall)
            sb.note_request(op, item_value, target_position);
    end

    // Offer one request item; entered and left at a falling edge
    task automatic send_item(op_t code, data_t value, pos_t pos);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        op <= code;
        item_value <= value;
        target_position <= pos;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold off the sender until every reply has come back
    task automatic drain_replies();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.awaited.size() != 0);
    endtask

    function automatic data_t pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return data_t'(int'($urandom_range(0, 8)) - 4);
        if (roll < 7)
            return sb.stored_value();
        if (roll == 7)
        begin
            case ($urandom_range(0, 3))
                0: return data_t'(32'h8000_0000);
                1: return data_t'(32'h7fff_ffff);
                2: return data_t'(0);
                default: return data_t'(-1);
            endcase
        end
        return data_t'($urandom);
    endfunction

    // Edges of every field and every special case
    task automatic run_directed();
        // empty list: search miss, delete out of range, ignored op
        send_item(OP_SEARCH, data_t'(7), pos_t'(0));
        send_item(OP_DELETE, data_t'(0), pos_t'(1));
        send_item(OP_UNUSED, data_t'(0), pos_t'(0));
        // fill to capacity with extremes and a duplicate
        send_item(OP_APPEND, data_t'(32'h8000_0000), pos_t'(0));
        send_item(OP_APPEND, data_t'(32'h7fff_ffff), pos_t'(0));
        send_item(OP_APPEND, data_t'(0), pos_t'(0));
        send_item(OP_APPEND, data_t'(-1), pos_t'(0));
        send_item(OP_APPEND, data_t'(-1), pos_t'(0));
        while (sb.shadow_count < LIST_CAPACITY)
            send_item(OP_APPEND, data_t'($urandom), pos_t'(0));
        // append to a full list
        send_item(OP_APPEND, data_t'(55), pos_t'(31));
        send_item(OP_SEARCH, data_t'(32'h7fff_ffff), pos_t'(0));
        send_item(OP_SEARCH, data_t'(-1), pos_t'(0));
        send_item(OP_SEARCH, data_t'(32'h1234_5678), pos_t'(0));
        send_item(OP_DELETE, data_t'(0), pos_t'(0));
        send_item(OP_DELETE, data_t'(0), pos_t'(31));
        send_item(OP_DELETE, data_t'(0), pos_t'(LIST_CAPACITY));
        send_item(OP_DELETE, data_t'(0), pos_t'(1));
        send_item(OP_UNUSED, data_t'(32'hffff_ffff), pos_t'(31));
    endtask

    // Random items, biased in stretches toward filling or draining the list
    task automatic run_random(int count);
        bit    growing;
        int    roll;
        op_t   code;
        data_t value;
        pos_t  pos;
        growing = 1'b1;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                growing = $urandom_range(0, 1);
            roll = $urandom_range(0, 99);
            if (growing)
                code = (roll < 55) ? OP_APPEND : (roll < 80) ? OP_SEARCH :
                       (roll < 97) ? OP_DELETE : OP_UNUSED;
            else
                code = (roll < 25) ? OP_APPEND : (roll < 55) ? OP_SEARCH :
                       (roll < 95) ? OP_DELETE : OP_UNUSED;
            value = ($urandom_range(0, 9) < 7 && code == OP_SEARCH) ?
                    sb.stored_value() : pick_value();
            if (sb.shadow_count > 0 && $urandom_range(0, 3) != 0)
                pos = pos_t'($urandom_range(1, sb.shadow_count));
            else
                pos = pos_t'($urandom_range(0, 31));
            send_item(code, value, pos);
        end
    endtask

    // Stop a hung run
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        op = OP_APPEND;
        item_value = '0;
        target_position = '0;
        rsp_stall = 1'b0;
        cycle_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        sb = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // phases: no idling, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 49; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 49; end
                default: begin idle_pct = 9; stall_pct <= 9; end
            endcase
            if (phase == 0)
                run_directed();
            run_random(RANDOM_PER_PHASE);
            drain_replies();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.awaited.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
